### rtl/core/cpse_pkg.sv
// Shared types and constants for the channel pulse signal extraction unit.
package cpse_pkg;

   localparam int SAMPLES_PER_PULSE_DEF = 20;
   localparam int FIFO_DEPTH_DEF        = 4;
   localparam int PEDESTAL_SAMPLES      = 3;
   localparam int KEEP_MAX              = 4;

   localparam int ADC_W   = 10;
   localparam int TOT_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int PED_W   = 12;
   localparam int VAL_W   = 13;
   localparam int SUM_W   = 15;
   localparam int PROD_W  = SUM_W + GAIN_W + 1;
   localparam int TRUNC_W = 23;
   localparam int RECIP_W = 22;
   localparam int QPROD_W = TRUNC_W + RECIP_W;
   localparam int QUO_W   = QPROD_W - 23;
   localparam int SIG_W   = 23;
   localparam int TOPC_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Division by the pedestal sample count is folded into a multiply by ceil(2^23/3).
   localparam logic [RECIP_W-1:0] RECIP_THIRD = 22'd2796203;
   localparam int RECIP_SHIFT = 23;
   // Half of 3*256, added to the magnitude for round-half-away-from-zero.
   localparam logic [PROD_W-1:0] ROUND_BIAS = 32'd384;
   localparam int SCALE_SHIFT = 8;

   localparam logic [TOPC_W-1:0] TOP_COUNT_RESET     = 3'd4;
   localparam logic [TOPC_W-1:0] TOP_COUNT_MAX       = 3'd4;
   localparam logic [TOT_W-1:0]  TOT_THRESHOLD_RESET = 16'd50;

   typedef logic signed [VAL_W-1:0] val_type;
   localparam val_type VAL_RESET = 13'sh1000;

   localparam logic signed [SIG_W:0] SIG_MAX = 24'sh3FFFFF;
   localparam logic signed [SIG_W:0] SIG_MIN = -24'sh400000;

   typedef enum logic {
      CSR_TOP_COUNT     = 1'b0,
      CSR_TOT_THRESHOLD = 1'b1
   } csr_index_type;

   // Summary of one finished pulse, handed from the front end to the back end.
   typedef struct packed {
      val_type [KEEP_MAX-1:0] largest;
      logic [GAIN_W-1:0]      gain;
      logic [TOT_W-1:0]       first_tot;
      logic                   tot_seen;
      logic                   over_seen;
   } pulse_sum_type;

endpackage

### rtl/core/cpse_front.sv
// Front end: frames samples into pulses and keeps pedestal, top values and ToT flags.
module cpse_front #(
   parameter int SAMPLES_PER_PULSE = cpse_pkg::SAMPLES_PER_PULSE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [cpse_pkg::ADC_W-1:0]  adc_sample,
   input  logic [cpse_pkg::TOT_W-1:0]  tot_sample,
   input  logic [cpse_pkg::GAIN_W-1:0] gain,
   input  logic [cpse_pkg::TOT_W-1:0]  tot_threshold,
   input  logic                        fifo_full,
   output logic                        push,
   output cpse_pkg::pulse_sum_type     push_data
);
   import cpse_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES_PER_PULSE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_PULSE - 1);
   localparam logic [IDX_W-1:0] PED_END  = IDX_W'(PEDESTAL_SAMPLES);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PED_W-1:0] ped_ff, ped_in;
   val_type          lv_ff [KEEP_MAX];
   val_type          lv_in [KEEP_MAX];
   logic [TOT_W-1:0] first_tot_ff, first_tot_in;
   logic             tot_seen_ff, tot_seen_in;
   logic             over_ff, over_in;

   logic             accept;
   logic             in_pedestal;
   logic             last;
   logic [PED_W-1:0] adc3;
   val_type          v;
   logic [KEEP_MAX-1:0] gt;

   assign in_ready    = !fifo_full;
   assign accept      = in_valid && in_ready;
   assign in_pedestal = idx_ff < PED_END;
   assign last        = idx_ff == LAST_IDX;

   // Three times the sample minus the pedestal sum never leaves 13 signed bits.
   assign adc3 = PED_W'({adc_sample, 1'b0}) + PED_W'(adc_sample);
   assign v    = VAL_W'($signed({1'b0, adc3}) - $signed({1'b0, ped_ff}));

   always_comb begin
      tot_seen_in  = tot_seen_ff || (tot_sample != '0);
      first_tot_in = (tot_sample != '0 && !tot_seen_ff) ? tot_sample : first_tot_ff;
      over_in      = over_ff || (tot_sample > tot_threshold);
      ped_in       = in_pedestal ? ped_ff + PED_W'(adc_sample) : ped_ff;

      // The list is sorted descending, so the compare results form a thermometer code.
      for (int i = 0; i < KEEP_MAX; i++) begin
         gt[i] = v > lv_ff[i];
      end
      lv_in[0] = (gt[0] && !in_pedestal) ? v : lv_ff[0];
      for (int i = 1; i < KEEP_MAX; i++) begin
         if (in_pedestal || !gt[i]) begin
            lv_in[i] = lv_ff[i];
         end else if (gt[i-1]) begin
            lv_in[i] = lv_ff[i-1];
         end else begin
            lv_in[i] = v;
         end
      end

      idx_in = last ? '0 : idx_ff + 1'b1;
   end

   always_comb begin
      push = accept && last;
      for (int i = 0; i < KEEP_MAX; i++) begin
         push_data.largest[i] = lv_in[i];
      end
      push_data.gain      = gain;
      push_data.first_tot = first_tot_in;
      push_data.tot_seen  = tot_seen_in;
      push_data.over_seen = over_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         ped_ff       <= '0;
         first_tot_ff <= '0;
         tot_seen_ff  <= 1'b0;
         over_ff      <= 1'b0;
         for (int i = 0; i < KEEP_MAX; i++) begin
            lv_ff[i] <= VAL_RESET;
         end
      end else if (accept) begin
         idx_ff <= idx_in;
         if (last) begin
            ped_ff       <= '0;
            first_tot_ff <= '0;
            tot_seen_ff  <= 1'b0;
            over_ff      <= 1'b0;
            for (int i = 0; i < KEEP_MAX; i++) begin
               lv_ff[i] <= VAL_RESET;
            end
         end else begin
            ped_ff       <= ped_in;
            first_tot_ff <= first_tot_in;
            tot_seen_ff  <= tot_seen_in;
            over_ff      <= over_in;
            for (int i = 0; i < KEEP_MAX; i++) begin
               lv_ff[i] <= lv_in[i];
            end
         end
      end
   end

endmodule

### rtl/core/cpse_fifo.sv
// Small queue of pulse summaries between the front end and the back end.
module cpse_fifo #(
   parameter int DEPTH = cpse_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cpse_pkg::pulse_sum_type push_data,
   output logic                    full,
   input  logic                    pop,
   output cpse_pkg::pulse_sum_type pop_data,
   output logic                    empty
);
   import cpse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pulse_sum_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == FULL_CNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/cpse_back.sv
// Back end: sums kept values, applies gain, divides by 3, rounds (or uses ToT*16), saturates.
module cpse_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [cpse_pkg::TOPC_W-1:0] top_count,
   input  logic                        fifo_empty,
   output logic                        pop,
   input  cpse_pkg::pulse_sum_type     pop_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [cpse_pkg::SIG_W-1:0]  signal,
   output logic                        tot_used,
   output logic                        tot_over_threshold
);
   import cpse_pkg::*;

   logic adv;

   // Stage 1: sum of the selected values.
   logic                     s1_valid_ff;
   logic signed [SUM_W-1:0]  s1_sum_ff, s1_sum_in;
   logic [GAIN_W-1:0]        s1_gain_ff;
   logic [TOT_W-1:0]         s1_tot_ff;
   logic                     s1_tot_used_ff, s1_over_ff;

   // Stage 2: gain product.
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic [TOT_W-1:0]         s2_tot_ff;
   logic                     s2_tot_used_ff, s2_over_ff;

   // Stage 3: rounded magnitude scaled down by 256.
   logic                     s3_valid_ff;
   logic [TRUNC_W-1:0]       s3_trunc_ff, s3_trunc_in;
   logic                     s3_neg_ff;
   logic [TOT_W-1:0]         s3_tot_ff;
   logic                     s3_tot_used_ff, s3_over_ff;

   // Stage 4: reciprocal product for the divide by three.
   logic                     s4_valid_ff;
   logic [QPROD_W-1:0]       s4_qprod_ff;
   logic                     s4_neg_ff;
   logic [TOT_W-1:0]         s4_tot_ff;
   logic                     s4_tot_used_ff, s4_over_ff;

   // Stage 5: output register.
   logic                     out_valid_ff;
   logic [SIG_W-1:0]         signal_ff, signal_in;
   logic                     tot_used_ff, over_ff;

   logic [TOPC_W-1:0]        n_sel;
   logic [PROD_W-1:0]        mag;
   logic [QUO_W-1:0]         quo;
   logic signed [SIG_W:0]    wide;

   assign adv = !out_valid_ff || out_ready;
   assign pop = adv && !fifo_empty;

   always_comb begin
      if (top_count == '0) begin
         n_sel = TOPC_W'(1);
      end else if (top_count > TOP_COUNT_MAX) begin
         n_sel = TOP_COUNT_MAX;
      end else begin
         n_sel = top_count;
      end
      s1_sum_in = '0;
      for (int i = 0; i < KEEP_MAX; i++) begin
         if (n_sel > TOPC_W'(i)) begin
            s1_sum_in = s1_sum_in + SUM_W'($signed(pop_data.largest[i]));
         end
      end
   end

   always_comb begin
      mag         = s2_prod_ff[PROD_W-1] ? PROD_W'(-s2_prod_ff) : PROD_W'(s2_prod_ff);
      s3_trunc_in = TRUNC_W'((mag + ROUND_BIAS) >> SCALE_SHIFT);
   end

   always_comb begin
      quo = QUO_W'(s4_qprod_ff >> RECIP_SHIFT);
      if (s4_tot_used_ff) begin
         wide = $signed({1'b0, (SIG_W)'({s4_tot_ff, 4'b0000})});
      end else if (s4_neg_ff) begin
         wide = -$signed({1'b0, (SIG_W)'(quo)});
      end else begin
         wide = $signed({1'b0, (SIG_W)'(quo)});
      end
      if (wide > SIG_MAX) begin
         signal_in = SIG_W'(SIG_MAX);
      end else if (wide < SIG_MIN) begin
         signal_in = SIG_W'(SIG_MIN);
      end else begin
         signal_in = SIG_W'(wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= !fifo_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sum_ff      <= s1_sum_in;
         s1_gain_ff     <= pop_data.gain;
         s1_tot_ff      <= pop_data.first_tot;
         s1_tot_used_ff <= pop_data.tot_seen;
         s1_over_ff     <= pop_data.over_seen;

         s2_prod_ff     <= s1_sum_ff * $signed({1'b0, s1_gain_ff});
         s2_tot_ff      <= s1_tot_ff;
         s2_tot_used_ff <= s1_tot_used_ff;
         s2_over_ff     <= s1_over_ff;

         s3_trunc_ff    <= s3_trunc_in;
         s3_neg_ff      <= s2_prod_ff[PROD_W-1];
         s3_tot_ff      <= s2_tot_ff;
         s3_tot_used_ff <= s2_tot_used_ff;
         s3_over_ff     <= s2_over_ff;

         s4_qprod_ff    <= QPROD_W'(s3_trunc_ff) * QPROD_W'(RECIP_THIRD);
         s4_neg_ff      <= s3_neg_ff;
         s4_tot_ff      <= s3_tot_ff;
         s4_tot_used_ff <= s3_tot_used_ff;
         s4_over_ff     <= s3_over_ff;

         signal_ff      <= signal_in;
         tot_used_ff    <= s4_tot_used_ff;
         over_ff        <= s4_over_ff;
      end
   end

   assign out_valid          = out_valid_ff;
   assign signal             = signal_ff;
   assign tot_used           = tot_used_ff;
   assign tot_over_threshold = over_ff;

endmodule

### rtl/core/channel_pulse_signal_extract_unit.sv
// Channel pulse signal extraction unit: top level with configuration registers.
//
// The req_ channel carries one ADC/ToT sample pair per transaction. A free counter
// frames every SAMPLES_PER_PULSE transactions as one pulse; the first three ADC
// samples form the pedestal, and the largest pedestal-subtracted values of the
// rest are kept. The gain field is used only with the last sample of a pulse.
// The rsp_ channel returns one transaction per pulse: the signal in signed Q18.4,
// with the ToT-used flag on rsp_tuser.
// Throughput is one sample per cycle while the pulse queue is not full. The result
// of a pulse is queued when the last sample is accepted and then passes through the
// five registered back-end stages (sum, gain multiply, round, reciprocal multiply,
// output register) to rsp_tvalid. When rsp_tready is low with a result waiting,
// the back end holds its stages and pulse summaries collect in a FIFO_DEPTH-entry
// queue; req_tready drops only once that queue is full.
// Reset clears the sample counter and all pulse state, and sets top_count to 4
// and tot_threshold to 50. csr_ready is always high; writes take effect at once.
module channel_pulse_signal_extract_unit #(
   parameter int SAMPLES_PER_PULSE = cpse_pkg::SAMPLES_PER_PULSE_DEF,
   parameter int FIFO_DEPTH        = cpse_pkg::FIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // adc_sample[9:0], tot_sample[25:10], gain[41:26], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // signal[22:0], tot_over_threshold[23]
   output logic        rsp_tuser,   // tot_used
   input  logic        csr_valid,
   output logic        csr_ready,
   input  cpse_pkg::csr_index_type           csr_index,
   input  logic [cpse_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cpse_pkg::*;

   logic [TOPC_W-1:0] top_count_ff;
   logic [TOT_W-1:0]  tot_threshold_ff;

   logic          push, pop, fifo_full, fifo_empty;
   pulse_sum_type push_data, pop_data;
   logic [SIG_W-1:0] signal;
   logic          tot_used, tot_over;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff     <= TOP_COUNT_RESET;
         tot_threshold_ff <= TOT_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TOP_COUNT:     top_count_ff     <= csr_data[TOPC_W-1:0];
            CSR_TOT_THRESHOLD: tot_threshold_ff <= csr_data[TOT_W-1:0];
            default: ;
         endcase
      end
   end

   cpse_front #(
      .SAMPLES_PER_PULSE(SAMPLES_PER_PULSE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .adc_sample    (req_tdata[9:0]),
      .tot_sample    (req_tdata[25:10]),
      .gain          (req_tdata[41:26]),
      .tot_threshold (tot_threshold_ff),
      .fifo_full     (fifo_full),
      .push          (push),
      .push_data     (push_data)
   );

   cpse_fifo #(
      .DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty)
   );

   cpse_back u_back (
      .clock              (clock),
      .reset              (reset),
      .top_count          (top_count_ff),
      .fifo_empty         (fifo_empty),
      .pop                (pop),
      .pop_data           (pop_data),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .signal             (signal),
      .tot_used           (tot_used),
      .tot_over_threshold (tot_over)
   );

   assign rsp_tdata = {tot_over, signal};
   assign rsp_tuser = tot_used;

endmodule

### tb/tb_channel_pulse_signal_extract_unit.sv
// Self-checking testbench for the channel pulse signal extraction unit.
module tb_channel_pulse_signal_extract_unit;
   import cpse_pkg::*;

   localparam int PULSE_LEN = SAMPLES_PER_PULSE_DEF;
   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      logic signed [SIG_W-1:0] signal;
      logic                    tot_used;
      logic                    tot_over;
   } pulse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_index_type csr_index = CSR_TOP_COUNT;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow of the configuration and of the running pulse state.
   logic [TOPC_W-1:0] cfg_top_count = TOP_COUNT_RESET;
   logic [TOT_W-1:0]  cfg_tot_threshold = TOT_THRESHOLD_RESET;
   int                pulse_pos = 0;
   int                pedestal_acc = 0;
   int                top_values [KEEP_MAX];
   logic [TOT_W-1:0]  first_tot_value = '0;
   logic              tot_found = 1'b0;
   logic              over_found = 1'b0;

   pulse_result_type  pending_results [$];
   int                error_count = 0;
   logic              idle_enable = 1'b1;

   channel_pulse_signal_extract_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (idle_enable) begin
         rsp_tready <= ($urandom_range(99) >= 32);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic clear_pulse_state();
      pulse_pos = 0;
      pedestal_acc = 0;
      foreach (top_values[i]) top_values[i] = int'(VAL_RESET);
      first_tot_value = '0;
      tot_found = 1'b0;
      over_found = 1'b0;
   endtask

   // Folds one accepted sample into the shadow state; queues a result on the last one.
   task automatic track_sample(input logic [ADC_W-1:0] adc, input logic [TOT_W-1:0] tot,
                               input logic [GAIN_W-1:0] gain);
      int value;
      int keep;
      int sum;
      longint prod;
      longint mag;
      longint quo;
      longint sig;
      pulse_result_type res;
      if (tot != 0 && !tot_found) begin
         tot_found = 1'b1;
         first_tot_value = tot;
      end
      if (tot > cfg_tot_threshold) over_found = 1'b1;
      if (pulse_pos < PEDESTAL_SAMPLES) begin
         pedestal_acc = (pedestal_acc + int'(adc)) & 12'hFFF;
      end else begin
         value = PEDESTAL_SAMPLES * int'(adc) - pedestal_acc;
         for (int i = 0; i < KEEP_MAX; i++) begin
            if (value > top_values[i]) begin
               for (int j = KEEP_MAX - 1; j > i; j--) top_values[j] = top_values[j-1];
               top_values[i] = value;
               break;
            end
         end
      end
      if (pulse_pos + 1 < PULSE_LEN) begin
         pulse_pos++;
         return;
      end
      if (tot_found) begin
         sig = longint'(first_tot_value) * 16;
      end else begin
         keep = int'(cfg_top_count);
         if (keep < 1) keep = 1;
         if (keep > KEEP_MAX) keep = KEEP_MAX;
         sum = 0;
         for (int i = 0; i < keep; i++) sum += top_values[i];
         prod = longint'(sum) * longint'(gain);
         mag = (prod < 0) ? -prod : prod;
         quo = (mag + PEDESTAL_SAMPLES * 128) / (PEDESTAL_SAMPLES * 256);
         sig = (prod < 0) ? -quo : quo;
      end
      if (sig > 4194303) sig = 4194303;
      if (sig < -4194304) sig = -4194304;
      res.signal = sig[SIG_W-1:0];
      res.tot_used = tot_found;
      res.tot_over = over_found;
      pending_results = {pending_results, res};
      clear_pulse_state();
   endtask

   always @(posedge clock) begin
      pulse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result signal=%0d tot_used=%0b over=%0b", $time,
                     $signed(rsp_tdata[SIG_W-1:0]), rsp_tuser, rsp_tdata[23]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[SIG_W-1:0] !== want.signal) begin
               $display("%0t: signal expected %0d actual %0d", $time, want.signal,
                        $signed(rsp_tdata[SIG_W-1:0]));
               error_count++;
            end
            if (rsp_tuser !== want.tot_used) begin
               $display("%0t: tot_used expected %0b actual %0b", $time, want.tot_used,
                        rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[23] !== want.tot_over) begin
               $display("%0t: tot_over_threshold expected %0b actual %0b", $time,
                        want.tot_over, rsp_tdata[23]);
               error_count++;
            end
         end
      end
   end

   // Called at a rising edge; returns at the edge where the transaction was accepted.
   task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TOT_W-1:0] tot,
                              input logic [GAIN_W-1:0] gain);
      while (idle_enable && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, gain, tot, adc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_sample(adc, tot, gain);
   endtask

   task automatic send_pulse(input logic [ADC_W-1:0] adc_seq [PULSE_LEN],
                             input logic [TOT_W-1:0] tot_seq [PULSE_LEN],
                             input logic [GAIN_W-1:0] gain);
      for (int i = 0; i < PULSE_LEN; i++) begin
         // Gain only matters on the last sample; the others carry noise.
         send_sample(adc_seq[i], tot_seq[i],
                     (i == PULSE_LEN - 1) ? gain : GAIN_W'($urandom));
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_TOP_COUNT) begin
         cfg_top_count = value[TOPC_W-1:0];
      end else begin
         cfg_tot_threshold = value;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops the sender until every queued result has come back and the pipeline is empty.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_amplitude_extremes();
      logic [ADC_W-1:0] adc_seq [PULSE_LEN];
      logic [TOT_W-1:0] tot_seq [PULSE_LEN];
      // Zero pedestal and a full-scale tail under the reset configuration.
      for (int i = 0; i < PULSE_LEN; i++) begin
         adc_seq[i] = (i < PEDESTAL_SAMPLES) ? 10'd0 : 10'd1023;
         tot_seq[i] = '0;
      end
      send_pulse(adc_seq, tot_seq, 16'hFFFF);
      // Full-scale pedestal with an empty tail gives the most negative sum.
      for (int i = 0; i < PULSE_LEN; i++) adc_seq[i] = (i < PEDESTAL_SAMPLES) ? 10'd1023 : 10'd0;
      send_pulse(adc_seq, tot_seq, 16'hFFFF);
      drain_results();
   endtask

   task automatic test_tot_paths();
      logic [ADC_W-1:0] adc_seq [PULSE_LEN];
      logic [TOT_W-1:0] tot_seq [PULSE_LEN];
      // A full-scale ToT on a pedestal sample wins and raises the flag.
      for (int i = 0; i < PULSE_LEN; i++) begin
         adc_seq[i] = ADC_W'($urandom);
         tot_seq[i] = '0;
      end
      tot_seq[1] = 16'hFFFF;
      send_pulse(adc_seq, tot_seq, 16'd4096);
      // First ToT sits at the threshold, a later one just above it.
      for (int i = 0; i < PULSE_LEN; i++) tot_seq[i] = '0;
      tot_seq[8] = TOT_THRESHOLD_RESET;
      tot_seq[PULSE_LEN-1] = TOT_THRESHOLD_RESET + 16'd1;
      send_pulse(adc_seq, tot_seq, 16'd0);
      drain_results();
   endtask

   task automatic test_register_limits();
      logic [ADC_W-1:0] adc_seq [PULSE_LEN];
      logic [TOT_W-1:0] tot_seq [PULSE_LEN];
      for (int i = 0; i < PULSE_LEN; i++) begin
         adc_seq[i] = (i < PEDESTAL_SAMPLES) ? 10'd5 : ADC_W'($urandom);
         tot_seq[i] = '0;
      end
      // Upper data bits must be dropped; zero is treated as one.
      write_csr(CSR_TOP_COUNT, 16'hFFF8);
      write_csr(CSR_TOT_THRESHOLD, 16'd0);
      tot_seq[3] = 16'd0;
      send_pulse(adc_seq, tot_seq, 16'hFFFF);
      drain_results();
      write_csr(CSR_TOP_COUNT, 16'h0007);
      write_csr(CSR_TOT_THRESHOLD, 16'hFFFF);
      tot_seq[PULSE_LEN-1] = 16'hFFFF;
      send_pulse(adc_seq, tot_seq, 16'h8000);
      drain_results();
   endtask

   task automatic send_random_pulse();
      logic [ADC_W-1:0] adc_seq [PULSE_LEN];
      logic [TOT_W-1:0] tot_seq [PULSE_LEN];
      logic [GAIN_W-1:0] gain;
      int adc_mode;
      int tot_mode;
      int peak_at;
      int level;
      int near;
      adc_mode = $urandom_range(3);
      tot_mode = $urandom_range(5);
      peak_at = $urandom_range(PEDESTAL_SAMPLES, PULSE_LEN - 5);
      level = $urandom_range(1023);
      for (int i = 0; i < PULSE_LEN; i++) begin
         case (adc_mode)
            0: adc_seq[i] = ADC_W'($urandom);
            1: begin
               if (i < PEDESTAL_SAMPLES) begin
                  adc_seq[i] = ADC_W'($urandom_range(63));
               end else if (i >= peak_at && i < peak_at + 4) begin
                  adc_seq[i] = ADC_W'($urandom_range(1023, 200));
               end else begin
                  adc_seq[i] = ADC_W'($urandom_range(80));
               end
            end
            2: adc_seq[i] = (i < PEDESTAL_SAMPLES) ? ADC_W'($urandom_range(1023, 960))
                                                   : ADC_W'($urandom_range(100));
            default: adc_seq[i] = ADC_W'(level);
         endcase
         tot_seq[i] = '0;
      end
      // At least half of the pulses carry no ToT so that the amplitude path gets exercised.
      case (tot_mode)
         3: tot_seq[$urandom_range(PULSE_LEN - 1)] = TOT_W'($urandom_range(65535, 1));
         4: for (int i = 0; i < PULSE_LEN; i++)
               if ($urandom_range(99) < 30) tot_seq[i] = TOT_W'($urandom);
         5: for (int k = 0; k < 3; k++) begin
               near = int'(cfg_tot_threshold) + $urandom_range(2) - 1;
               if (near < 0) near = 0;
               if (near > 65535) near = 65535;
               tot_seq[$urandom_range(PULSE_LEN - 1)] = TOT_W'(near);
            end
         default: ;
      endcase
      case ($urandom_range(9))
         0: gain = '0;
         1: gain = '1;
         2: gain = 16'h1000;
         default: gain = GAIN_W'($urandom);
      endcase
      send_pulse(adc_seq, tot_seq, gain);
   endtask

   task automatic test_random_pulses();
      logic [TOPC_W-1:0] top_choice [8] = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6};
      logic [CSR_DATA_W-1:0] thr;
      for (int phase = 0; phase < 12; phase++) begin
         write_csr(CSR_TOP_COUNT,
                   {13'($urandom), top_choice[phase % 8]});
         case (phase % 4)
            0: thr = 16'd0;
            1: thr = 16'hFFFF;
            2: thr = TOT_THRESHOLD_RESET;
            default: thr = CSR_DATA_W'($urandom);
         endcase
         write_csr(CSR_TOT_THRESHOLD, thr);
         // Two phases run without any idling on either side.
         idle_enable = !(phase == 4 || phase == 9);
         repeat ($urandom_range(12, 5)) send_random_pulse();
         drain_results();
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      clear_pulse_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_amplitude_extremes();
      test_tot_paths();
      test_register_limits();
      test_random_pulses();
      drain_results();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### channel_pulse_signal_extract_unit.f
rtl/core/cpse_pkg.sv
rtl/core/cpse_front.sv
rtl/core/cpse_fifo.sv
rtl/core/cpse_back.sv
rtl/core/channel_pulse_signal_extract_unit.sv
tb/tb_channel_pulse_signal_extract_unit.sv
